// ===== rtl/ity_pkg.sv =====
// Shared types, token codes and the operator priority function
// for the infix-to-postfix reorder block. No dependencies.
package ity_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam logic [3:0] K_NUMBER   = 4'd0;
	localparam logic [3:0] K_VARIABLE = 4'd1;
	localparam logic [3:0] K_POSTFIX  = 4'd2;
	localparam logic [3:0] K_NEGATE   = 4'd3;
	localparam logic [3:0] K_FUNCTION = 4'd4;
	localparam logic [3:0] K_POWER    = 4'd5;
	localparam logic [3:0] K_OPEN     = 4'd6;
	localparam logic [3:0] K_CLOSE    = 4'd7;
	localparam logic [3:0] K_OPERATOR = 4'd8;
	localparam logic [3:0] K_END      = 4'd9;

	localparam logic [3:0] OP_PLUS   = 4'd0;
	localparam logic [3:0] OP_MINUS  = 4'd1;
	localparam logic [3:0] OP_TIMES  = 4'd2;
	localparam logic [3:0] OP_DIVIDE = 4'd3;
	localparam logic [3:0] OP_MOD    = 4'd4;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED = 2'd2;

	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] code;
	} entry_t;

	typedef struct packed {
		logic   we;
		entry_t data;
	} mem_wr_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  code;
		logic [63:0] value;
		logic        eoe;
		logic [1:0]  err;
	} res_t;

	function automatic logic [1:0] prio(input logic [3:0] kind, input logic [3:0] code);
		logic [1:0] p;
		p = 2'd0;
		if (kind == K_OPERATOR) begin
			if (code == OP_PLUS || code == OP_MINUS) p = 2'd1;
			else if (code == OP_TIMES || code == OP_DIVIDE) p = 2'd2;
			else if (code == OP_MOD) p = 2'd3;
		end
		return p;
	endfunction

endpackage

// ===== rtl/ity_stack_mem.sv =====
// Operator stack storage: one write port, one registered read port.
// Depends on ity_pkg for the entry type.
module ity_stack_mem
	import ity_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int AW = $clog2(STACK_DEPTH)
) (
	input  logic          clk,
	input  mem_wr_t       wr,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [STACK_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[waddr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ity_seq.sv =====
// Token sequencer: dispatches each token, pushes and pops the stack
// memory, and produces result words. Depends on ity_pkg.
module ity_seq
	import ity_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int AW = $clog2(STACK_DEPTH),
	parameter int CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [3:0]    in_kind,
	input  logic [3:0]    in_code,
	input  logic [63:0]   in_value,
	input  logic          in_last,
	input  logic          out_free,
	output logic          emit,
	output res_t          emit_res,
	output mem_wr_t       mem_wr,
	output logic [AW-1:0] waddr,
	output logic [AW-1:0] raddr,
	input  entry_t        rdata
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PASS   = 4'd1;
	localparam logic [3:0] S_PUSH1  = 4'd2;
	localparam logic [3:0] S_PUSH2  = 4'd3;
	localparam logic [3:0] S_OPEN   = 4'd4;
	localparam logic [3:0] S_CLOSE  = 4'd5;
	localparam logic [3:0] S_CLFN   = 4'd6;
	localparam logic [3:0] S_OPER   = 4'd7;
	localparam logic [3:0] S_FLUSH  = 4'd8;
	localparam logic [3:0] S_END    = 4'd9;
	localparam logic [3:0] S_CLHOLD = 4'd10;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_m1;
	logic          top_ok_q, emitted_q, emitted_d;
	logic [3:0]    kind_q, code_q;
	logic [63:0]   value_q;
	logic          last_q;
	entry_t        hold_q;
	logic          cnt_zero, cnt_one, full_one, no_room2, top_is_fn;

	assign cnt_m1    = cnt_q - CW'(1);
	assign raddr     = cnt_m1[AW-1:0];
	assign waddr     = cnt_q[AW-1:0];
	assign cnt_zero  = (cnt_q == '0);
	assign cnt_one   = (cnt_q == CW'(1));
	assign full_one  = (cnt_q >= CW'(STACK_DEPTH));
	assign no_room2  = (({1'b0, cnt_q} + (CW+1)'(2)) > (CW+1)'(STACK_DEPTH));
	assign top_is_fn = (rdata.kind == K_NEGATE) || (rdata.kind == K_FUNCTION) ||
		(rdata.kind == K_POWER);
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		emitted_d = emitted_q;
		emit      = 1'b0;
		emit_res  = '0;
		mem_wr    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					emitted_d = 1'b0;
					unique case (in_kind)
						K_NUMBER, K_VARIABLE, K_POSTFIX: state_d = S_PASS;
						K_NEGATE, K_FUNCTION, K_POWER:   state_d = S_PUSH1;
						K_OPEN:                          state_d = S_OPEN;
						K_CLOSE:                         state_d = S_CLOSE;
						K_OPERATOR:                      state_d = S_OPER;
						default:                         state_d = S_END;
					endcase
				end
			end
			S_PASS: begin
				if (out_free) begin
					emit           = 1'b1;
					emit_res.kind  = kind_q;
					emit_res.code  = (kind_q == K_POSTFIX) ? code_q : 4'd0;
					emit_res.value = (kind_q == K_NUMBER) ? value_q : 64'd0;
					emit_res.eoe   = last_q && cnt_zero;
					emit_res.err   = ERR_NONE;
					emitted_d      = 1'b1;
					state_d        = S_END;
				end
			end
			S_PUSH1: begin
				if (no_room2) begin
					if (out_free) begin
						emit          = 1'b1;
						emit_res.kind = kind_q;
						emit_res.code = code_q;
						emit_res.eoe  = last_q && cnt_zero;
						emit_res.err  = ERR_OVERFLOW;
						emitted_d     = 1'b1;
						state_d       = S_END;
					end
				end else begin
					mem_wr.we        = 1'b1;
					mem_wr.data.kind = kind_q;
					mem_wr.data.code = code_q;
					cnt_d            = cnt_q + CW'(1);
					state_d          = S_PUSH2;
				end
			end
			S_PUSH2: begin
				mem_wr.we        = 1'b1;
				mem_wr.data.kind = K_OPEN;
				mem_wr.data.code = 4'd0;
				cnt_d            = cnt_q + CW'(1);
				state_d          = S_END;
			end
			S_OPEN: begin
				if (full_one) begin
					if (out_free) begin
						emit          = 1'b1;
						emit_res.kind = kind_q;
						emit_res.code = code_q;
						emit_res.eoe  = last_q && cnt_zero;
						emit_res.err  = ERR_OVERFLOW;
						emitted_d     = 1'b1;
						state_d       = S_END;
					end
				end else begin
					mem_wr.we        = 1'b1;
					mem_wr.data.kind = K_OPEN;
					mem_wr.data.code = 4'd0;
					cnt_d            = cnt_q + CW'(1);
					state_d          = S_END;
				end
			end
			S_CLOSE: begin
				if (cnt_zero) begin
					if (out_free) begin
						emit          = 1'b1;
						emit_res.kind = K_CLOSE;
						emit_res.code = code_q;
						emit_res.eoe  = last_q;
						emit_res.err  = ERR_UNMATCHED;
						emitted_d     = 1'b1;
						state_d       = S_END;
					end
				end else if (top_ok_q) begin
					if (rdata.kind != K_OPEN) begin
						if (last_q && (cnt_q == CW'(2))) begin
							// hold the word until the bottom entry is known
							cnt_d   = cnt_m1;
							state_d = S_CLHOLD;
						end else if (out_free) begin
							emit          = 1'b1;
							emit_res.kind = rdata.kind;
							emit_res.code = rdata.code;
							emitted_d     = 1'b1;
							cnt_d         = cnt_m1;
						end
					end else begin
						cnt_d   = cnt_m1;
						state_d = S_CLFN;
					end
				end
			end
			S_CLHOLD: begin
				if (top_ok_q && out_free) begin
					emit          = 1'b1;
					emit_res.kind = hold_q.kind;
					emit_res.code = hold_q.code;
					emit_res.eoe  = (rdata.kind == K_OPEN);
					emitted_d     = 1'b1;
					state_d       = S_CLOSE;
				end
			end
			S_CLFN: begin
				if (cnt_zero) begin
					state_d = S_END;
				end else if (top_ok_q) begin
					if (top_is_fn) begin
						if (out_free) begin
							emit          = 1'b1;
							emit_res.kind = rdata.kind;
							emit_res.code = rdata.code;
							emit_res.eoe  = last_q && cnt_one;
							emitted_d     = 1'b1;
							cnt_d         = cnt_m1;
							state_d       = S_END;
						end
					end else begin
						state_d = S_END;
					end
				end
			end
			S_OPER: begin
				if (!cnt_zero && !top_ok_q) begin
					state_d = S_OPER;
				end else if (!cnt_zero &&
					(prio(K_OPERATOR, code_q) <= prio(rdata.kind, rdata.code))) begin
					if (out_free) begin
						emit          = 1'b1;
						emit_res.kind = rdata.kind;
						emit_res.code = rdata.code;
						emitted_d     = 1'b1;
						cnt_d         = cnt_m1;
					end
				end else if (full_one) begin
					if (out_free) begin
						emit          = 1'b1;
						emit_res.kind = K_OPERATOR;
						emit_res.code = code_q;
						emit_res.eoe  = last_q && cnt_zero;
						emit_res.err  = ERR_OVERFLOW;
						emitted_d     = 1'b1;
						state_d       = S_END;
					end
				end else begin
					mem_wr.we        = 1'b1;
					mem_wr.data.kind = K_OPERATOR;
					mem_wr.data.code = code_q;
					cnt_d            = cnt_q + CW'(1);
					state_d          = S_END;
				end
			end
			S_FLUSH: begin
				if (cnt_zero) begin
					state_d = S_IDLE;
				end else if (top_ok_q && out_free) begin
					emit          = 1'b1;
					emit_res.kind = rdata.kind;
					emit_res.code = rdata.code;
					emit_res.eoe  = cnt_one;
					emitted_d     = 1'b1;
					cnt_d         = cnt_m1;
					if (cnt_one) state_d = S_IDLE;
				end
			end
			S_END: begin
				if (last_q && !cnt_zero) begin
					state_d = S_FLUSH;
				end else if (last_q && !emitted_q) begin
					if (out_free) begin
						emit          = 1'b1;
						emit_res.kind = K_END;
						emit_res.eoe  = 1'b1;
						emitted_d     = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			top_ok_q  <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			top_ok_q  <= (cnt_d == cnt_q) && !mem_wr.we;
			emitted_q <= emitted_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= in_kind;
			code_q  <= in_code;
			value_q <= in_value;
			last_q  <= in_last;
		end
		if (state_q == S_CLOSE) begin
			hold_q <= rdata;
		end
	end

endmodule

// ===== rtl/infix_to_postfix_reorder.sv =====
// Infix-to-postfix reorder: an accepted token is latched, then a pass-through
// word is emitted from the PASS state into the output register. A push writes
// the stack directly; each pop waits for the registered read of the stack memory
// after every stack pointer update. A new token is taken only once the last is done.
// Reset clears the stack pointer and control; stack memory is not cleared.
// Depends on ity_pkg, ity_stack_mem and ity_seq.
module infix_to_postfix_reorder
	import ity_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // [3:0] token_code, [67:4] number_value, rest zero
	input  logic [3:0]  s_tuser,  // [3:0] token_kind
	input  logic        s_tlast,  // last_token
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [3:0] out_code, [67:4] out_value, rest zero
	output logic [5:0]  m_tuser,  // [3:0] out_kind, [5:4] error_code
	output logic        m_tlast   // end_of_expression
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	mem_wr_t       mem_wr;
	logic [AW-1:0] waddr, raddr;
	entry_t        rdata;
	logic          emit, out_free;
	res_t          emit_res;
	logic          ov_q;
	res_t          res_q;

	ity_stack_mem #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW         (AW)
	) u_mem (
		.clk  (clk),
		.wr   (mem_wr),
		.waddr(waddr),
		.raddr(raddr),
		.rdata(rdata)
	);

	ity_seq #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW         (AW),
		.CW         (CW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_kind (s_tuser),
		.in_code (s_tdata[3:0]),
		.in_value(s_tdata[67:4]),
		.in_last (s_tlast),
		.out_free(out_free),
		.emit    (emit),
		.emit_res(emit_res),
		.mem_wr  (mem_wr),
		.waddr   (waddr),
		.raddr   (raddr),
		.rdata   (rdata)
	);

	assign out_free = !ov_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {4'd0, res_q.value, res_q.code};
	assign m_tuser  = {res_q.err, res_q.kind};
	assign m_tlast  = res_q.eoe;

endmodule

// ===== bench/postfix_order_checker.sv =====
// Checker for infix_to_postfix_reorder: watches both stream channels, predicts
// the postfix words with its own operator stack and compares them in order.
// Depends on ity_pkg.
`timescale 1ns / 100ps

module postfix_order_checker
	import ity_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,  // [3:0] token_code, [67:4] number_value, rest zero
	input  logic [3:0]  s_tuser,  // [3:0] token_kind
	input  logic        s_tlast,  // last_token
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,  // [3:0] out_code, [67:4] out_value, rest zero
	input  logic [5:0]  m_tuser,  // [3:0] out_kind, [5:4] error_code
	input  logic        m_tlast,  // end_of_expression
	output int          fail_count,
	output int          pending
);

	entry_t op_stack [DEPTH];
	int     used;
	int     emitted;
	res_t   postfix_q [$];
	res_t   seen;
	res_t   want;

	function automatic int rank_of(input logic [3:0] kind, input logic [3:0] code);
		if (kind != K_OPERATOR)
			return 0;
		case (code)
		OP_PLUS, OP_MINUS:   return 1;
		OP_TIMES, OP_DIVIDE: return 2;
		OP_MOD:              return 3;
		default:             return 0;
		endcase
	endfunction

	task automatic put_word(input logic [3:0] kind, input logic [3:0] code,
			input logic [63:0] value, input logic [1:0] err);
		res_t w;
		w.kind  = kind;
		w.code  = code;
		w.value = value;
		w.eoe   = 1'b0;
		w.err   = err;
		postfix_q = {postfix_q, w};
		emitted++;
	endtask

	task automatic pop_word();
		used--;
		put_word(op_stack[used].kind, op_stack[used].code, 64'd0, ERR_NONE);
	endtask

	task automatic push_entry(input logic [3:0] kind, input logic [3:0] code);
		op_stack[used].kind = kind;
		op_stack[used].code = code;
		used++;
	endtask

	task automatic reorder_token(input logic [3:0] kind, input logic [3:0] code,
			input logic [63:0] value, input logic last);
		emitted = 0;
		case (kind)
		K_NUMBER:   put_word(K_NUMBER, 4'd0, value, ERR_NONE);
		K_VARIABLE: put_word(K_VARIABLE, 4'd0, 64'd0, ERR_NONE);
		K_POSTFIX:  put_word(K_POSTFIX, code, 64'd0, ERR_NONE);
		K_NEGATE, K_FUNCTION, K_POWER: begin
			if (used + 2 > DEPTH) begin
				put_word(kind, code, 64'd0, ERR_OVERFLOW);
			end else begin
				push_entry(kind, code);
				push_entry(K_OPEN, 4'd0);
			end
		end
		K_OPEN: begin
			if (used >= DEPTH)
				put_word(kind, code, 64'd0, ERR_OVERFLOW);
			else
				push_entry(K_OPEN, 4'd0);
		end
		K_CLOSE: begin
			while (used > 0 && op_stack[used - 1].kind != K_OPEN)
				pop_word();
			if (used == 0) begin
				put_word(K_CLOSE, code, 64'd0, ERR_UNMATCHED);
			end else begin
				used--;
				// release a function, negation or power waiting under the bracket
				if (used > 0 && (op_stack[used - 1].kind == K_NEGATE ||
						op_stack[used - 1].kind == K_FUNCTION ||
						op_stack[used - 1].kind == K_POWER))
					pop_word();
			end
		end
		K_OPERATOR: begin
			while (used > 0 && rank_of(K_OPERATOR, code) <=
					rank_of(op_stack[used - 1].kind, op_stack[used - 1].code))
				pop_word();
			if (used >= DEPTH)
				put_word(kind, code, 64'd0, ERR_OVERFLOW);
			else
				push_entry(K_OPERATOR, code);
		end
		default: ;
		endcase
		if (last) begin
			while (used > 0)
				pop_word();
			if (emitted == 0)
				put_word(K_END, 4'd0, 64'd0, ERR_NONE);
			postfix_q[postfix_q.size() - 1].eoe = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used = 0;
			postfix_q.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				reorder_token(s_tuser, s_tdata[3:0], s_tdata[67:4], s_tlast);
			if (m_tvalid && m_tready) begin
				seen.kind  = m_tuser[3:0];
				seen.code  = m_tdata[3:0];
				seen.value = m_tdata[67:4];
				seen.eoe   = m_tlast;
				seen.err   = m_tuser[5:4];
				if (postfix_q.size() == 0) begin
					$display("%0t: unexpected postfix word: kind %0d code %0d value %h eoe %0b err %0d",
						$time, seen.kind, seen.code, seen.value, seen.eoe, seen.err);
					fail_count <= fail_count + 1;
				end else begin
					want = postfix_q.pop_front();
					if (seen !== want) begin
						$display("%0t: expected k%0d c%0d v%h e%0b r%0d, actual k%0d c%0d v%h e%0b r%0d",
							$time, want.kind, want.code, want.value, want.eoe, want.err,
							seen.kind, seen.code, seen.value, seen.eoe, seen.err);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= postfix_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the infix_to_postfix_reorder bench: clock, reset, token stimulus with
// random gaps and stalls, watchdog and verdict. Depends on ity_pkg, the DUT and the checker.
`timescale 1ns / 100ps

module tb_top;
	import ity_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 160;
	localparam int DRAIN_CYCLES   = 80;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  code;
		logic [63:0] value;
		logic        last;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	int          fail_count;
	int          pending;
	int          stall_cycles = 0;
	int          ready_hold = 0;
	logic        m_fire = 1'b0;
	bit          burst = 1'b0;
	int          items_sent = 0;
	int          n_expr = 0;
	token_t      expr_q [$];

	infix_to_postfix_reorder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	postfix_order_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_fire <= m_tvalid && m_tready;
	end

	always @(negedge clk) begin
		if (m_fire)
			ready_hold = burst ? 0 : $urandom_range(5);
		else if (ready_hold > 0)
			ready_hold--;
		m_tready <= (ready_hold == 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_token(input logic [3:0] kind, input logic [3:0] code,
			input logic [63:0] value, input logic last);
		token_t t;
		t.kind  = kind;
		t.code  = code;
		t.value = value;
		t.last  = last;
		expr_q = {expr_q, t};
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(7))
		0:       return 64'd0;
		1:       return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [3:0] rand_op();
		if ($urandom_range(19) == 0)
			return 4'($urandom_range(15, 5));
		return 4'($urandom_range(4));
	endfunction

	task automatic add_operand();
		if ($urandom_range(3) == 0)
			add_token(K_VARIABLE, 4'($urandom_range(15)), rand_value(), 1'b0);
		else
			add_token(K_NUMBER, 4'($urandom_range(15)), rand_value(), 1'b0);
		if ($urandom_range(5) == 0)
			add_token(K_POSTFIX, 4'($urandom_range(15)), rand_value(), 1'b0);
	endtask

	task automatic add_nest();
		case ($urandom_range(3))
		0:       add_token(K_OPEN, 4'($urandom_range(15)), rand_value(), 1'b0);
		1:       add_token(K_FUNCTION, 4'($urandom_range(15)), rand_value(), 1'b0);
		2:       add_token(K_NEGATE, 4'($urandom_range(15)), rand_value(), 1'b0);
		default: add_token(K_POWER, 4'($urandom_range(15)), rand_value(), 1'b0);
		endcase
	endtask

	task automatic mark_last();
		expr_q[expr_q.size() - 1].last = 1'b1;
	endtask

	task automatic build_expression(input int operands, input int nest_pct);
		int left;
		int open_n;
		bit want_operand;
		left = operands;
		open_n = 0;
		want_operand = 1'b1;
		while (left > 0 || open_n > 0) begin
			if (want_operand) begin
				if ($urandom_range(99) < nest_pct) begin
					add_nest();
					open_n++;
				end else begin
					add_operand();
					left--;
					want_operand = 1'b0;
				end
			end else if (open_n > 0 && (left == 0 || $urandom_range(2) == 0)) begin
				add_token(K_CLOSE, 4'($urandom_range(15)), rand_value(), 1'b0);
				open_n--;
			end else begin
				add_token(K_OPERATOR, rand_op(), rand_value(), 1'b0);
				want_operand = 1'b1;
			end
		end
		mark_last();
	endtask

	task automatic build_deep();
		int n;
		n = $urandom_range(24, 17);
		repeat (n) add_nest();
		add_operand();
		add_token(K_OPERATOR, rand_op(), rand_value(), 1'b0);
		add_operand();
		repeat (n) add_token(K_CLOSE, 4'($urandom_range(15)), rand_value(), 1'b0);
		mark_last();
	endtask

	task automatic build_noise();
		repeat ($urandom_range(8, 3))
			add_token(4'($urandom_range(15)), 4'($urandom_range(15)), rand_value(),
				$urandom_range(3) == 0);
	endtask

	task automatic send_word(input token_t t);
		int gap;
		gap = burst ? 0 : $urandom_range(5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, t.value, t.code};
		s_tuser  <= t.kind;
		s_tlast  <= t.last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (t.kind <= K_OPERATOR)
			items_sent++;
	endtask

	task automatic send_all();
		foreach (expr_q[i])
			send_word(expr_q[i]);
		expr_q.delete();
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_token(K_NUMBER, 4'd15, 64'd0, 1'b0);
		add_token(K_OPERATOR, OP_PLUS, '1, 1'b0);
		add_token(K_NUMBER, 4'd0, '1, 1'b0);
		add_token(K_OPERATOR, OP_TIMES, 64'd0, 1'b0);
		add_token(K_VARIABLE, 4'd0, 64'd0, 1'b0);
		add_token(K_OPERATOR, OP_MOD, 64'd0, 1'b0);
		add_token(K_FUNCTION, 4'd15, 64'd0, 1'b0);
		add_token(K_NUMBER, 4'd0, 64'h0123_4567_89ab_cdef, 1'b0);
		add_token(K_CLOSE, 4'd0, 64'd0, 1'b0);
		add_token(K_OPERATOR, OP_MINUS, 64'd0, 1'b0);
		add_token(K_NEGATE, 4'd0, 64'd0, 1'b0);
		add_token(K_VARIABLE, 4'd15, '1, 1'b0);
		add_token(K_POSTFIX, 4'd15, '1, 1'b0);
		add_token(K_CLOSE, 4'd0, 64'd0, 1'b0);
		add_token(K_OPERATOR, OP_DIVIDE, 64'd0, 1'b0);
		add_token(K_POWER, 4'd9, 64'd0, 1'b0);
		add_token(K_OPEN, 4'd0, 64'd0, 1'b0);
		add_token(K_NUMBER, 4'd0, 64'h8000_0000_0000_0001, 1'b0);
		add_token(K_CLOSE, 4'd0, 64'd0, 1'b0);
		add_token(K_CLOSE, 4'd0, 64'd0, 1'b0);
		// unknown operator code pops everything, then last flushes
		add_token(K_OPERATOR, 4'd7, 64'd0, 1'b1);
		add_token(K_CLOSE, 4'd5, 64'd0, 1'b1);
		add_token(4'd12, 4'd3, '1, 1'b0);
		add_token(4'd15, 4'd0, 64'd0, 1'b1);
		add_token(K_OPEN, 4'd0, 64'd0, 1'b0);
		add_token(K_VARIABLE, 4'd0, 64'd0, 1'b0);
		add_token(K_OPERATOR, OP_PLUS, 64'd0, 1'b0);
		add_token(K_OPERATOR, 4'd15, 64'd0, 1'b0);
		add_token(K_NUMBER, 4'd0, 64'd5, 1'b0);
		add_token(K_OPERATOR, OP_TIMES, 64'd0, 1'b0);
		add_token(K_CLOSE, 4'd3, 64'd0, 1'b1);
		send_all();
		wait_drain();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			burst = ($urandom_range(4) == 0);
			if (n_expr % 8 == 3)
				build_deep();
			else if ($urandom_range(6) == 0)
				build_noise();
			else
				build_expression($urandom_range(6, 1), $urandom_range(45, 10));
			send_all();
			if (n_expr % 5 == 4)
				wait_drain();
			n_expr++;
		end

		burst = 1'b0;
		wait_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
